// ----- hw/rtl/rlew_pkg.sv -----
// Package for the run-length word decoder.
// Holds the parse phase and status codes, the register indexes and the result record.
// No dependencies.
package rlew_pkg;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 16;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RUN_TAG  = 1'b0,
    CFG_DEST_CAP = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_COUNT  = 2'd2,
    PH_VALUE  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ODD_SOURCE = 3'd1,
    ST_ODD_SIZE   = 3'd2,
    ST_UNDERFLOW  = 3'd3,
    ST_OVERFLOW   = 3'd4,
    ST_MISMATCH   = 3'd5
  } status_t;

  typedef struct packed {
    logic              has_run;
    logic [WORD_W-1:0] run_value;
    logic [WORD_W-1:0] run_length;
    logic              done_res;
    status_t           status;
    logic [WORD_W-1:0] decoded_words;
  } res_t;

endpackage

// ----- hw/rtl/rlew_parser.sv -----
// Byte pairing, phase machine and word accounting of the run-length word decoder.
// Depends on rlew_pkg; produces at most one result record per accepted byte.
module rlew_parser
  import rlew_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [BYTE_W-1:0] src_byte,
  input  logic              last_byte,
  input  logic [WORD_W-1:0] run_tag,
  input  logic [WORD_W-1:0] dest_capacity,
  output logic              res_valid,
  output res_t              res
);

  logic              pend_r, pend_nxt;
  logic [BYTE_W-1:0] low_r, low_nxt;
  phase_t            phase_r, phase_nxt;
  logic [WORD_W-1:0] size_r, size_nxt;
  logic [WORD_W-1:0] cnt_r, cnt_nxt;
  logic [WORD_W-1:0] words_r, words_nxt;
  status_t           err_r, err_nxt;

  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] take_len;
  logic [WORD_W:0]   take_sum;
  logic              take_over;
  logic              emit;
  logic [WORD_W-1:0] emit_val;
  logic [WORD_W-1:0] emit_len;
  status_t           end_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      low_r   <= '0;
      phase_r <= PH_HEADER;
      size_r  <= '0;
      cnt_r   <= '0;
      words_r <= '0;
      err_r   <= ST_OK;
    end else if (acc) begin
      pend_r  <= pend_nxt;
      low_r   <= low_nxt;
      phase_r <= phase_nxt;
      size_r  <= size_nxt;
      cnt_r   <= cnt_nxt;
      words_r <= words_nxt;
      err_r   <= err_nxt;
    end
  end

  assign word      = {src_byte, low_r};
  // A literal counts one word, a run counts its stored length.
  assign take_len  = (phase_r == PH_VALUE) ? cnt_r : WORD_W'(1);
  assign take_sum  = {1'b0, words_r} + {1'b0, take_len};
  assign take_over = take_sum > {1'b0, dest_capacity};

  always_comb begin
    pend_nxt   = pend_r;
    low_nxt    = low_r;
    phase_nxt  = phase_r;
    size_nxt   = size_r;
    cnt_nxt    = cnt_r;
    words_nxt  = words_r;
    err_nxt    = err_r;
    emit       = 1'b0;
    emit_val   = '0;
    emit_len   = '0;
    end_status = ST_OK;

    if (!pend_r) begin
      low_nxt  = src_byte;
      pend_nxt = 1'b1;
    end else begin
      pend_nxt = 1'b0;
      if (err_r == ST_OK) begin
        unique case (phase_r)
          PH_HEADER: begin
            size_nxt  = word;
            phase_nxt = PH_BODY;
            if (word[0]) err_nxt = ST_ODD_SIZE;
          end
          PH_BODY: begin
            if (word != run_tag) begin
              if (take_over) begin
                err_nxt = ST_OVERFLOW;
              end else begin
                words_nxt = take_sum[WORD_W-1:0];
                emit      = 1'b1;
                emit_val  = word;
                emit_len  = WORD_W'(1);
              end
            end else begin
              phase_nxt = PH_COUNT;
            end
          end
          PH_COUNT: begin
            cnt_nxt   = word;
            phase_nxt = PH_VALUE;
          end
          PH_VALUE: begin
            phase_nxt = PH_BODY;
            if (take_over) begin
              err_nxt = ST_OVERFLOW;
            end else begin
              words_nxt = take_sum[WORD_W-1:0];
              // drop zero-length runs
              if (cnt_r != '0) begin
                emit     = 1'b1;
                emit_val = word;
                emit_len = cnt_r;
              end
            end
          end
          default: phase_nxt = PH_HEADER;
        endcase
      end
    end

    if (last_byte) begin
      if (!pend_r)
        end_status = ST_ODD_SOURCE;
      else if (err_nxt != ST_OK)
        end_status = err_nxt;
      else if (phase_nxt == PH_COUNT || phase_nxt == PH_VALUE)
        end_status = ST_UNDERFLOW;
      else if (words_nxt != {1'b0, size_nxt[WORD_W-1:1]})
        end_status = ST_MISMATCH;
    end

    res_valid         = acc && (emit || last_byte);
    res.has_run       = emit;
    res.run_value     = emit_val;
    res.run_length    = emit_len;
    res.done_res      = last_byte;
    res.status        = end_status;
    res.decoded_words = words_nxt;

    // End of stream: return all stream state to its reset value.
    if (last_byte) begin
      pend_nxt  = 1'b0;
      low_nxt   = '0;
      phase_nxt = PH_HEADER;
      size_nxt  = '0;
      cnt_nxt   = '0;
      words_nxt = '0;
      err_nxt   = ST_OK;
    end
  end

  a_status_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status != ST_OK |-> res.done_res)
    else $error("status set on a result that does not end the stream");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.has_run |-> res.run_length != '0 && err_r == ST_OK)
    else $error("descriptor emitted with zero length or under an error");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    acc && last_byte |=> phase_r == PH_HEADER && words_r == '0 && !pend_r && err_r == ST_OK)
    else $error("stream state not cleared after the last byte");

endmodule

// ----- hw/rtl/rlew_out_buf.sv -----
// Two-entry result queue of the run-length word decoder.
// Depends on rlew_pkg; parts the parser from a stalling receiver.
module rlew_out_buf
  import rlew_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic full,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_data
);

  res_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign full      = count_r == 2'd2;
  assign out_valid = count_r != 2'd0;
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("result written into a full queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count out of range");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd1) == (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

// ----- hw/rtl/rlew_run_length_decoder_core.sv -----
// Top level of the run-length word decoder: configuration registers, parser, result queue.
// Depends on rlew_pkg, rlew_parser and rlew_out_buf.
//
// Usage:
//   The compressed stream enters one byte per transaction on in_src_byte, with
//   in_last_byte marking its final byte. Bytes pair into little-endian words;
//   the first word is the decoded size, then literals and run triples follow.
//   Each completed literal or nonzero run gives one descriptor transaction on
//   the out_ channel; the last byte always gives one, carrying out_done_res,
//   the final out_status and out_decoded_words.
//   A result is registered in the result queue before it appears on the out_ channel.
//   Throughput: one byte per cycle while in_stall is low; the parse step is
//   combinational, between the stream state registers and the two-entry result queue.
//   When the receiver stalls, the queue holds up to two results; in_stall rises
//   only when both entries are occupied.
//   Reset (synchronous, rst_n low) clears the stream state and the queue,
//   sets run_tag to 0 and dest_capacity to 65535. Write cfg_ registers only
//   while the block is idle; index 0 is run_tag, index 1 dest_capacity.
module rlew_run_length_decoder_core
  import rlew_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_src_byte,
  input  logic                 in_last_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_has_run,
  output logic [WORD_W-1:0]    out_run_value,
  output logic [WORD_W-1:0]    out_run_length,
  output logic                 out_done_res,
  output logic [2:0]           out_status,
  output logic [WORD_W-1:0]    out_decoded_words
);

  logic [WORD_W-1:0] run_tag_r;
  logic [WORD_W-1:0] dest_cap_r;
  logic              in_acc;
  logic              res_valid;
  res_t              res;
  logic              q_full;
  res_t              q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_tag_r  <= '0;
      dest_cap_r <= '1;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RUN_TAG:  run_tag_r  <= cfg_wdata;
        CFG_DEST_CAP: dest_cap_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;
  assign in_acc   = in_valid && !in_stall;

  rlew_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (in_acc),
    .src_byte      (in_src_byte),
    .last_byte     (in_last_byte),
    .run_tag       (run_tag_r),
    .dest_capacity (dest_cap_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  rlew_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (q_data)
  );

  assign out_has_run       = q_data.has_run;
  assign out_run_value     = q_data.run_value;
  assign out_run_length    = q_data.run_length;
  assign out_done_res      = q_data.done_res;
  assign out_status        = q_data.status;
  assign out_decoded_words = q_data.decoded_words;

endmodule
